/* hw/rtl/buhr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buhr_pkg
// Shared types and constants of the bounded undo/redo history.
// ----------------------------------------------------------------------------
package buhr_pkg;

	localparam int DATA_W    = 32;
	localparam int CNT_OUT_W = 5;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_UNDO  = 2'd1,
		OP_REDO  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NO_UNDO = 2'd1,
		ST_NO_REDO = 2'd2
	} status_t;

	typedef struct packed {
		op_t               operation;
		logic [DATA_W-1:0] entry_data;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic                 top_valid;
		logic [DATA_W-1:0]    top_data;
		logic [CNT_OUT_W-1:0] undo_depth;
		logic [CNT_OUT_W-1:0] redo_depth;
		logic                 evicted;
	} rsp_t;

	// Shift actions applied along the cell row.
	typedef struct packed {
		logic push;
		logic undo;
		logic redo;
	} ctrl_t;

endpackage

/* hw/rtl/buhr_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buhr_cell
// One position of the undo stack and of the redo stack. Words move to the
// neighbor cell on push, undo and redo.
// ----------------------------------------------------------------------------
module buhr_cell (
	input  logic                   clk,
	input  buhr_pkg::ctrl_t        ctrl,
	input  logic [buhr_pkg::DATA_W-1:0] u_prev,
	input  logic [buhr_pkg::DATA_W-1:0] u_next,
	input  logic [buhr_pkg::DATA_W-1:0] r_prev,
	input  logic [buhr_pkg::DATA_W-1:0] r_next,
	output logic [buhr_pkg::DATA_W-1:0] u_word,
	output logic [buhr_pkg::DATA_W-1:0] r_word
);
	import buhr_pkg::*;

	logic [DATA_W-1:0] u_q;
	logic [DATA_W-1:0] r_q;

	always_ff @(posedge clk) begin
		if (ctrl.push || ctrl.redo) begin
			u_q <= u_prev;
		end else if (ctrl.undo) begin
			u_q <= u_next;
		end
		// redo stack moves opposite to the undo stack
		if (ctrl.undo) begin
			r_q <= r_prev;
		end else if (ctrl.redo) begin
			r_q <= r_next;
		end
	end

	assign u_word = u_q;
	assign r_word = r_q;

endmodule

/* hw/rtl/bounded_undo_redo_history_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_undo_redo_history_top
// Undo/redo history held in a row of cells: undo stack with its top in the
// first cell, redo stack beside it. A full push drops the word off the end.
// The result strobes in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle; busy stays low, all work is a
// single shift of the cell row and a count update.
// Reset: counts and strobe clear; stored words are unknown until pushed.
// The receiver cannot stall; every result is shown for one cycle only.
// ----------------------------------------------------------------------------
module bounded_undo_redo_history_top #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  buhr_pkg::cmd_t cmd,
	output logic           result_valid,
	output buhr_pkg::rsp_t rsp
);
	import buhr_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] undo_q, redo_q;
	logic [CNT_W-1:0] undo_d, redo_d;
	logic             valid_q;
	status_t          status_q, status_d;
	logic             evicted_q, evicted_d;
	ctrl_t            ctrl;
	logic             fire;

	logic [DATA_W-1:0] u_word [DEPTH];
	logic [DATA_W-1:0] r_word [DEPTH];
	logic [DATA_W-1:0] u_head;

	assign busy = 1'b0;
	assign fire = start && !busy;

	always_comb begin
		ctrl      = '0;
		undo_d    = undo_q;
		redo_d    = redo_q;
		status_d  = ST_DONE;
		evicted_d = 1'b0;
		if (fire) begin
			case (cmd.operation)
				OP_PUSH: begin
					ctrl.push = 1'b1;
					redo_d    = '0;
					if (undo_q == CNT_W'(DEPTH)) begin
						evicted_d = 1'b1;
					end else begin
						undo_d = undo_q + 1'b1;
					end
				end
				OP_UNDO: begin
					if (undo_q == '0) begin
						status_d = ST_NO_UNDO;
					end else begin
						ctrl.undo = 1'b1;
						undo_d    = undo_q - 1'b1;
						redo_d    = redo_q + 1'b1;
					end
				end
				OP_REDO: begin
					if (redo_q == '0) begin
						status_d = ST_NO_REDO;
					end else begin
						ctrl.redo = 1'b1;
						undo_d    = undo_q + 1'b1;
						redo_d    = redo_q - 1'b1;
					end
				end
				OP_CLEAR: begin
					undo_d = '0;
					redo_d = '0;
				end
				default: begin
					undo_d = undo_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			undo_q    <= '0;
			redo_q    <= '0;
			valid_q   <= 1'b0;
			status_q  <= ST_DONE;
			evicted_q <= 1'b0;
		end else begin
			undo_q    <= undo_d;
			redo_q    <= redo_d;
			valid_q   <= fire;
			status_q  <= status_d;
			evicted_q <= evicted_d;
		end
	end

	// feed the head cell: new word on push, redo top on redo
	assign u_head = ctrl.push ? cmd.entry_data : r_word[0];

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [DATA_W-1:0] u_prev, u_next, r_prev, r_next;
		if (k == 0) begin : g_head
			assign u_prev = u_head;
			assign r_prev = u_word[0];
		end else begin : g_body
			assign u_prev = u_word[k-1];
			assign r_prev = r_word[k-1];
		end
		if (k == DEPTH - 1) begin : g_tail
			assign u_next = '0;
			assign r_next = '0;
		end else begin : g_link
			assign u_next = u_word[k+1];
			assign r_next = r_word[k+1];
		end
		buhr_cell u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.u_prev (u_prev),
			.u_next (u_next),
			.r_prev (r_prev),
			.r_next (r_next),
			.u_word (u_word[k]),
			.r_word (r_word[k])
		);
	end

	always_comb begin
		rsp.status     = status_q;
		rsp.top_valid  = (undo_q != '0);
		rsp.top_data   = (undo_q != '0) ? u_word[0] : '0;
		rsp.undo_depth = CNT_OUT_W'(undo_q);
		rsp.redo_depth = CNT_OUT_W'(redo_q);
		rsp.evicted    = evicted_q;
	end

	assign result_valid = valid_q;

endmodule
